/* sv/whbm_pkg.sv */
// Shared types and constants for the windowed Hamming best-match block.
`default_nettype none
package whbm_pkg;
  localparam int unsigned DescW     = 256;
  localparam int unsigned CoordW    = 16;
  localparam int unsigned DistLimit = 128;
  localparam int unsigned DistW     = 9;
  localparam int unsigned HalfW     = 15;
  localparam int unsigned DimW      = 12;
  localparam int unsigned InDataW   = 2 * CoordW + DescW;
  localparam int unsigned OutDataW  = 56;

  localparam logic [1:0] RegHalf   = 2'd0;
  localparam logic [1:0] RegWidth  = 2'd1;
  localparam logic [1:0] RegHeight = 2'd2;

  localparam logic ReqLoad  = 1'b0;
  localparam logic ReqQuery = 1'b1;

  // Classified item travelling from front to back
  typedef struct packed {
    logic              is_query;
    logic              clear;
    logic              in_image;
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [DescW-1:0]  desc;
  } cmd_t;

  // Population count of a 256-bit word as a balanced tree of additions
  function automatic logic [DistW-1:0] popcount256(input logic [DescW-1:0] v);
    logic [DistW-1:0] s [64];
    for (int i = 0; i < 64; i++) begin
      s[i] = DistW'(v[4*i]) + DistW'(v[4*i+1]) + DistW'(v[4*i+2]) + DistW'(v[4*i+3]);
    end
    for (int w = 32; w > 0; w = w >> 1) begin
      for (int i = 0; i < w; i++) begin
        s[i] = s[2*i] + s[2*i+1];
      end
    end
    return s[0];
  endfunction
endpackage
`default_nettype wire

/* sv/whbm_front.sv */
// Front part: accepts input items and marks queries whose centre lies inside the image.
`default_nettype none
module whbm_front
  import whbm_pkg::*;
#(
  parameter int unsigned FracBits = 4
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              s_valid_i,
  output      logic              s_ready_o,
  input  wire logic              req_type_i,
  input  wire logic              clear_i,
  input  wire logic [InDataW-1:0] data_i,
  input  wire logic [DimW-1:0]   img_w_i,
  input  wire logic [DimW-1:0]   img_h_i,
  output      logic              q_valid_o,
  input  wire logic              q_ready_i,
  output      cmd_t              q_cmd_o
);
  localparam int unsigned LimW = DimW + FracBits + 1;

  logic              valid_q;
  cmd_t              cmd_q;
  logic signed [CoordW-1:0] px, py;
  logic signed [LimW-1:0]   xmax, ymax;
  logic              in_image;

  assign px   = data_i[CoordW-1:0];
  assign py   = data_i[2*CoordW-1:CoordW];
  assign xmax = LimW'({1'b0, img_w_i}) << FracBits;
  assign ymax = LimW'({1'b0, img_h_i}) << FracBits;
  assign in_image = !px[CoordW-1] && !py[CoordW-1] &&
                    (LimW'(px) <= xmax) && (LimW'(py) <= ymax);

  assign s_ready_o = !valid_q || q_ready_i;
  assign q_valid_o = valid_q;
  assign q_cmd_o   = cmd_q;

  // Hold one classified item in the queue slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (s_ready_o) begin
      valid_q <= s_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_valid_i && s_ready_o) begin
      cmd_q.is_query <= (req_type_i == ReqQuery);
      cmd_q.clear    <= clear_i;
      cmd_q.in_image <= in_image;
      cmd_q.x        <= px;
      cmd_q.y        <= py;
      cmd_q.desc     <= data_i[InDataW-1:2*CoordW];
    end
  end
endmodule
`default_nettype wire

/* sv/whbm_back.sv */
// Back part: stores entries and scans the table one entry per cycle for a query.
`default_nettype none
module whbm_back
  import whbm_pkg::*;
#(
  parameter int unsigned MaxEntries = 1024
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              q_valid_i,
  output      logic              q_ready_o,
  input  wire cmd_t              q_cmd_i,
  input  wire logic [HalfW-1:0]  half_i,
  output      logic              r_valid_o,
  input  wire logic              r_ready_i,
  output      logic [OutDataW-1:0] r_data_o
);
  localparam int unsigned IdxW = (MaxEntries > 1) ? $clog2(MaxEntries) : 1;
  localparam int unsigned CntW = $clog2(MaxEntries + 1);
  localparam int unsigned WinW = CoordW + 2;

  typedef enum logic [1:0] {StIdle, StScan, StEval, StDone} state_e;

  logic [DescW-1:0]    desc_mem [MaxEntries];
  logic [2*CoordW-1:0] pos_mem  [MaxEntries];

  state_e            state_q;
  logic [CntW-1:0]   count_q;
  logic [CntW-1:0]   scan_q;
  logic              rd_valid_q;
  logic [IdxW-1:0]   rd_idx_q;
  logic [DescW-1:0]  rd_desc_q;
  logic [2*CoordW-1:0] rd_pos_q;
  logic [DescW-1:0]  qdesc_q;
  logic signed [WinW-1:0] xlo_q, xhi_q, ylo_q, yhi_q;
  logic [DistW-1:0]  best_q;
  logic [IdxW-1:0]   best_idx_q;
  logic [2*CoordW-1:0] best_pos_q;
  logic              found_q;
  logic              r_valid_q;
  logic [OutDataW-1:0] r_data_q;

  logic              in_win;
  logic [DistW-1:0]  hdist;
  logic signed [WinW-1:0] ex, ey;
  logic [CntW-1:0]   wr_idx;
  logic              take;

  assign take      = q_valid_i && q_ready_o;
  assign q_ready_o = (state_q == StIdle) && !r_valid_q;
  assign wr_idx    = q_cmd_i.clear ? '0 : count_q;

  // Store a loaded entry
  always_ff @(posedge clk_i) begin
    if (take && !q_cmd_i.is_query && (wr_idx < CntW'(MaxEntries))) begin
      desc_mem[wr_idx[IdxW-1:0]] <= q_cmd_i.desc;
      pos_mem[wr_idx[IdxW-1:0]]  <= {q_cmd_i.y, q_cmd_i.x};
    end
  end

  // Read one entry per cycle during the scan
  always_ff @(posedge clk_i) begin
    rd_desc_q <= desc_mem[scan_q[IdxW-1:0]];
    rd_pos_q  <= pos_mem[scan_q[IdxW-1:0]];
    rd_idx_q  <= scan_q[IdxW-1:0];
  end

  assign ex   = WinW'($signed(rd_pos_q[CoordW-1:0]));
  assign ey   = WinW'($signed(rd_pos_q[2*CoordW-1:CoordW]));
  assign in_win = (ex > xlo_q) && (ex < xhi_q) && (ey > ylo_q) && (ey < yhi_q);
  assign hdist = popcount256(rd_desc_q ^ qdesc_q);

  assign r_valid_o = r_valid_q;
  assign r_data_o  = r_data_q;

  // Sequence loads, scans and result delivery
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      count_q    <= '0;
      scan_q     <= '0;
      rd_valid_q <= 1'b0;
      r_valid_q  <= 1'b0;
      found_q    <= 1'b0;
      best_q     <= DistW'(DistLimit);
    end else begin
      if (r_valid_q && r_ready_i) begin
        r_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (take) begin
            if (!q_cmd_i.is_query) begin
              if (wr_idx < CntW'(MaxEntries)) begin
                count_q <= wr_idx + 1'b1;
              end
            end else begin
              scan_q     <= '0;
              found_q    <= 1'b0;
              best_q     <= DistW'(DistLimit);
              rd_valid_q <= 1'b0;
              state_q    <= q_cmd_i.in_image ? StScan : StDone;
            end
          end
        end
        StScan: begin
          if (scan_q < count_q) begin
            scan_q     <= scan_q + 1'b1;
            rd_valid_q <= 1'b1;
          end else begin
            rd_valid_q <= 1'b0;
            state_q    <= StEval;
          end
          if (rd_valid_q && in_win && (hdist < best_q)) begin
            best_q     <= hdist;
            best_idx_q <= rd_idx_q;
            best_pos_q <= rd_pos_q;
            found_q    <= 1'b1;
          end
        end
        StEval: begin
          if (rd_valid_q && in_win && (hdist < best_q)) begin
            best_q     <= hdist;
            best_idx_q <= rd_idx_q;
            best_pos_q <= rd_pos_q;
            found_q    <= 1'b1;
          end
          rd_valid_q <= 1'b0;
          state_q    <= StDone;
        end
        StDone: begin
          if (!r_valid_q) begin
            r_valid_q <= 1'b1;
            state_q   <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  // Capture window bounds and query descriptor on each accepted item, and form the result
  always_ff @(posedge clk_i) begin
    if (take) begin
      qdesc_q <= q_cmd_i.desc;
      xlo_q <= WinW'($signed(q_cmd_i.x)) - WinW'(half_i);
      xhi_q <= WinW'($signed(q_cmd_i.x)) + WinW'(half_i);
      ylo_q <= WinW'($signed(q_cmd_i.y)) - WinW'(half_i);
      yhi_q <= WinW'($signed(q_cmd_i.y)) + WinW'(half_i);
    end
    if (state_q == StDone && !r_valid_q) begin
      if (found_q) begin
        r_data_q <= {5'd0, best_q[7:0], 10'(best_idx_q),
                     best_pos_q[2*CoordW-1:CoordW], best_pos_q[CoordW-1:0], 1'b1};
      end else begin
        r_data_q <= {5'd0, 8'(DistLimit), 10'd0, 16'd0, 16'd0, 1'b0};
      end
    end
  end
endmodule
`default_nettype wire

/* sv/windowed_hamming_best_match.sv */
// Top level of the windowed Hamming best-match block.
// Input stream s_axis: tuser = {clear_table, req_type} (req_type bit 0),
// tdata = pos_x, pos_y, desc_word0..3 from bit 0 up. A load stores one
// reference entry and gives no result; loads into a full table are dropped,
// and clear_table restarts the table at index 0.
// A query gives one result on m_axis: tdata = found, match_x, match_y,
// match_index, match_distance from bit 0 up, zero padded to 56 bits.
// A load passes through the front slot into the back part. A query scans
// every stored entry, one per cycle from a single-port table read; the
// table holds up to MaxEntries entries, 1024 by default. A centre outside
// the image skips the scan.
// The front slot takes the next item while the back part works.
// The result register holds while m_axis_tready is low; no new item enters
// the back part until the result has been taken.
// Reset empties the table and loads the register defaults: half size 3200,
// image 640 by 480. Configuration writes are always ready.
`default_nettype none
module windowed_hamming_best_match
  import whbm_pkg::*;
#(
  parameter int unsigned MaxEntries = 1024,
  parameter int unsigned FracBits   = 4
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid,
  output      logic                s_axis_tready,
  input  wire logic [InDataW-1:0]  s_axis_tdata,  // pos_x, pos_y, desc_word0..3
  input  wire logic [1:0]          s_axis_tuser,  // req_type, clear_table
  output      logic                m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output      logic [OutDataW-1:0] m_axis_tdata,  // found, match_x, match_y, index, distance
  input  wire logic                cfg_valid_i,
  output      logic                cfg_ready_o,
  input  wire logic [1:0]          cfg_index_i,
  input  wire logic [HalfW-1:0]    cfg_data_i
);
  logic [HalfW-1:0] half_q;
  logic [DimW-1:0]  img_w_q, img_h_q;
  logic             q_valid, q_ready;
  cmd_t             q_cmd;

  assign cfg_ready_o = 1'b1;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_q  <= HalfW'(3200);
      img_w_q <= DimW'(640);
      img_h_q <= DimW'(480);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegHalf:   half_q  <= cfg_data_i;
        RegWidth:  img_w_q <= cfg_data_i[DimW-1:0];
        RegHeight: img_h_q <= cfg_data_i[DimW-1:0];
        default: ;
      endcase
    end
  end

  whbm_front #(.FracBits(FracBits)) u_front (
    .clk_i, .rst_ni,
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .req_type_i(s_axis_tuser[0]),
    .clear_i   (s_axis_tuser[1]),
    .data_i    (s_axis_tdata),
    .img_w_i   (img_w_q),
    .img_h_i   (img_h_q),
    .q_valid_o (q_valid),
    .q_ready_i (q_ready),
    .q_cmd_o   (q_cmd)
  );

  whbm_back #(.MaxEntries(MaxEntries)) u_back (
    .clk_i, .rst_ni,
    .q_valid_i(q_valid),
    .q_ready_o(q_ready),
    .q_cmd_i  (q_cmd),
    .half_i   (half_q),
    .r_valid_o(m_axis_tvalid),
    .r_ready_i(m_axis_tready),
    .r_data_o (m_axis_tdata)
  );

`ifndef ASSERT_OFF
  // A result with found clear reports the no-match values
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[50:43] == 8'd128)
    else $error("no-match result has wrong distance");
  // A found result always carries a distance below the limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[50] == 1'b0)
    else $error("match distance not below limit");
  // The back part takes no item while a result waits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !q_ready)
    else $error("back part accepted item with result pending");
`endif
endmodule
`default_nettype wire
